### hdl/skvt_pkg.sv
// Shared definitions for the sorted key/value table: default sizes,
// operation and status codes, and the fixed widths of the stream fields.
// No dependencies.
package skvt_pkg;

   localparam int DEF_CAPACITY    = 64;
   localparam int DEF_KEY_WIDTH   = 32;
   localparam int DEF_VALUE_WIDTH = 32;

   // Stream field widths
   localparam int OP_W       = 2;
   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int POSITION_W = 7;
   localparam int COUNT_W    = 7;

   localparam int REQ_TDATA_W = KEY_W + VALUE_W;                 // 64
   localparam int RSP_TDATA_W = 48;                              // 46 bits used
   localparam int RSP_TUSER_W = STATUS_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

endpackage

### hdl/skvt_ram.sv
// Record store of the sorted key/value table: one write port and one
// read port with registered read data. Uses skvt_pkg for default sizes.
module skvt_ram
   import skvt_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   localparam int AW         = $clog2(CAPACITY)
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [KEY_WIDTH-1:0]   wr_key,
   input  logic [VALUE_WIDTH-1:0] wr_value,
   input  logic [AW-1:0]          rd_addr,
   output logic [KEY_WIDTH-1:0]   rd_key,
   output logic [VALUE_WIDTH-1:0] rd_value
);

   logic [KEY_WIDTH-1:0]   key_mem   [CAPACITY];
   logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
   logic [KEY_WIDTH-1:0]   rd_key_ff;
   logic [VALUE_WIDTH-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         value_mem[wr_addr] <= wr_value;
      end
   end

   // Read-during-write returns the old contents
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

### hdl/sorted_key_value_table.sv
// Sorted key/value table. Records are held in ascending unsigned key order.
// Request channel (req_): tuser carries the operation (find, insert, delete),
// tdata the key and value. Response channel (rsp_): one transfer per request
// with status, hit flag, lower-bound position, found value and record count.
// A request runs as a binary search followed, for an insert with room and a
// delete that hits, by a shift of the records above the position. Both go
// through the single read port and single write port of the record store,
// one access a cycle:
//   search  : each probe reads the middle record and narrows the bounds; a
//             last read at the lower bound checks for a match
//   shift   : insert moves the records one place up from the top down, then
//             writes the new record at the position; delete moves the
//             records above the position one place down.
// req_tready is high only while no request is in progress. A finished
// response waits in the output register; the block takes the next request
// while it waits, and holds the following response until the receiver
// takes the previous one. Reset empties the table at once; store contents
// are not cleared since data read at or above the count is never used.
module sorted_key_value_table
   import skvt_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // key[31:0], value[63:32]
   input  logic [OP_W-1:0]        req_tuser,   // op[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // position[6:0], found_value[38:7],
                                               // count[45:39], zero[47:46]
   output logic [RSP_TUSER_W-1:0] rsp_tuser    // status[1:0], hit[2]
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PROBE,
      ST_CHECK,
      ST_UP,
      ST_PLACE,
      ST_DOWN,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   op_type                 op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          lo_ff;
   logic [CW-1:0]          hi_ff;
   logic [CW-1:0]          mid_ff;
   logic [CW-1:0]          idx_ff;
   logic [AW-1:0]          wr_addr_ff;
   logic                   pend_ff;
   logic                   hit_ff;
   logic [VALUE_WIDTH-1:0] fval_ff;
   status_type             status_ff;
   logic                   rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff;

   logic [CW-1:0]          mid;
   logic [CW-1:0]          idx_dn;
   logic [CW-1:0]          idx_up;
   logic                   key_less;
   logic                   key_equal;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [KEY_WIDTH-1:0]   mem_wr_key;
   logic [VALUE_WIDTH-1:0] mem_wr_value;
   logic [AW-1:0]          mem_rd_addr;
   logic [KEY_WIDTH-1:0]   mem_rd_key;
   logic [VALUE_WIDTH-1:0] mem_rd_value;

   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dn    = idx_ff - CW'(1);
   assign idx_up    = idx_ff + CW'(1);
   // Shared comparator on the stored key just read
   assign key_less  = mem_rd_key < key_ff;
   assign key_equal = mem_rd_key == key_ff;

   always_comb begin
      mem_rd_addr  = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_addr_ff;
      mem_wr_key   = mem_rd_key;
      mem_wr_value = mem_rd_value;
      case (state_ff)
         ST_SEARCH: mem_rd_addr = (lo_ff < hi_ff) ? mid[AW-1:0] : lo_ff[AW-1:0];
         ST_UP: begin
            mem_rd_addr = idx_dn[AW-1:0];
            mem_wr_en   = pend_ff;
         end
         ST_DOWN: begin
            mem_rd_addr = idx_up[AW-1:0];
            mem_wr_en   = pend_ff;
         end
         ST_PLACE: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = lo_ff[AW-1:0];
            mem_wr_key   = key_ff;
            mem_wr_value = value_ff;
         end
         default: mem_rd_addr = '0;
      endcase
   end

   skvt_ram #(
      .CAPACITY    (CAPACITY),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_key   (mem_wr_key),
      .wr_value (mem_wr_value),
      .rd_addr  (mem_rd_addr),
      .rd_key   (mem_rd_key),
      .rd_value (mem_rd_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tready && (state_ff != ST_FINISH)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= op_type'(req_tuser);
                  key_ff   <= KEY_WIDTH'(req_tdata[KEY_W-1:0]);
                  value_ff <= VALUE_WIDTH'(req_tdata[KEY_W +: VALUE_W]);
                  lo_ff    <= '0;
                  hi_ff    <= count_ff;
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid;
                  state_ff <= ST_PROBE;
               end else begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_PROBE: begin
               if (key_less) begin
                  lo_ff <= mid_ff + CW'(1);
               end else begin
                  hi_ff <= mid_ff;
               end
               state_ff <= ST_SEARCH;
            end
            ST_CHECK: begin
               hit_ff    <= (lo_ff < count_ff) && key_equal;
               fval_ff   <= ((lo_ff < count_ff) && key_equal) ? mem_rd_value : '0;
               pend_ff   <= 1'b0;
               case (op_ff)
                  OP_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_ff <= STATUS_FULL;
                        state_ff  <= ST_FINISH;
                     end else begin
                        status_ff <= STATUS_OK;
                        idx_ff    <= count_ff;
                        state_ff  <= ST_UP;
                     end
                  end
                  OP_DELETE: begin
                     if ((lo_ff < count_ff) && key_equal) begin
                        status_ff <= STATUS_OK;
                        idx_ff    <= lo_ff;
                        state_ff  <= ST_DOWN;
                     end else begin
                        status_ff <= STATUS_NOT_FOUND;
                        state_ff  <= ST_FINISH;
                     end
                  end
                  default: begin
                     if ((lo_ff < count_ff) && key_equal) begin
                        status_ff <= STATUS_OK;
                     end else begin
                        status_ff <= STATUS_NOT_FOUND;
                     end
                     state_ff <= ST_FINISH;
                  end
               endcase
            end
            ST_UP: begin
               // Read the record below, write it one place up next cycle
               if (idx_ff > lo_ff) begin
                  wr_addr_ff <= idx_ff[AW-1:0];
                  idx_ff     <= idx_dn;
                  pend_ff    <= 1'b1;
               end else begin
                  pend_ff  <= 1'b0;
                  state_ff <= ST_PLACE;
               end
            end
            ST_PLACE: begin
               count_ff <= count_ff + CW'(1);
               state_ff <= ST_FINISH;
            end
            ST_DOWN: begin
               if (idx_up < count_ff) begin
                  wr_addr_ff <= idx_ff[AW-1:0];
                  idx_ff     <= idx_up;
                  pend_ff    <= 1'b1;
               end else begin
                  pend_ff  <= 1'b0;
                  count_ff <= count_ff - CW'(1);
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // Hold until the output register is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {2'b00, COUNT_W'(count_ff), VALUE_W'(fval_ff),
                                    POSITION_W'(lo_ff)};
                  rsp_tuser_ff  <= {hit_ff, status_ff};
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("record count beyond capacity");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_wr_en)
      else $error("store written while idle");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> (lo_ff <= hi_ff) && (hi_ff <= count_ff))
      else $error("search bounds out of order");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   a_start_search: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_SEARCH && lo_ff == '0)
      else $error("search not started on request transfer");
`endif

endmodule
